FILE: sv/emve_pkg.sv
// ----------------------------------------------------------------------------
// emve_pkg
// Shared constants and codes for the encoder velocity estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package emve_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_RESYNC = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic {
    REG_ANGLE   = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_t;

  localparam int ApcW    = 35;
  localparam int TsW     = 19;
  localparam int DtW     = 34;
  localparam int NumW    = 52;
  localparam int DvdW    = NumW + 16;
  localparam int RateW   = 48;
  localparam int MulW    = 48;
  localparam int ProdW   = ApcW + 1 + MulW;

  localparam logic [TsW-1:0]   TsDefault   = TsW'(1000);
  localparam logic [63:0]      TsMax       = 64'd500000;
  localparam logic [19:0]      UsPerS      = 20'd1000000;
  localparam logic [34:0]      ApcReset    = 35'd13176795;
  localparam logic [31:0]      TimeoutReset = 32'd100000;

endpackage

`default_nettype wire

FILE: sv/encoder_mixed_velocity_estimator.sv
// ----------------------------------------------------------------------------
// encoder_mixed_velocity_estimator
// Mixed time/frequency encoder velocity estimate with bit-serial divide
// and bit-serial angle and velocity scaling.
// ----------------------------------------------------------------------------
// Sequence: a sample, resync or unused code runs S_MINIT and the 48-step
//   shift-add multipliers (S_MUL) to S_DONE; a query first runs S_QPREP and
//   S_QCALC, then the 68-step bit-serial divider (S_DIV) when the rate is
//   updated, then S_QFIN. The block takes no new input until it is back in
//   S_IDLE; a result waiting in the output register does not block the next input.
// Reset (rst, synchronous): all estimator state zero, registers to defaults.
`default_nettype none

module encoder_mixed_velocity_estimator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [63:0]        stamp_us,
  input  wire logic signed [31:0] position_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      held_count,
  output logic signed [47:0]      angle_q16,
  output logic signed [31:0]      velocity_q16,
  output logic                    velocity_valid,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [34:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_QPREP, S_QCALC, S_DIV, S_QFIN, S_MINIT, S_MUL, S_DONE
  } state_t;

  state_t state;

  logic [34:0] apc;
  logic [31:0] timeout;

  logic [31:0]  held;
  logic [63:0]  pulse_time;
  logic [31:0]  pq_pos;
  logic [63:0]  pq_time;
  logic [31:0]  p_since;
  logic [47:0]  rate;

  logic [1:0]   op;
  logic [63:0]  t;

  logic [emve_pkg::TsW-1:0] ts;
  logic [63:0]  th;
  logic [31:0]  d;
  logic [emve_pkg::DtW-1:0] dt;
  logic         upd;

  logic [emve_pkg::DtW-1:0] rem;
  logic [emve_pkg::DvdW-1:0] dvd;
  logic [6:0]   cnt;

  logic [emve_pkg::ProdW-1:0] pv;
  logic [emve_pkg::ProdW-1:0] pa;

  // query front end
  logic [63:0] ts_raw;
  logic [emve_pkg::TsW-1:0] ts_fix;
  logic [emve_pkg::DtW-1:0] sum;
  logic [emve_pkg::DtW-1:0] dt_calc;
  logic        upd_calc;
  logic [31:0] dmag;
  logic [emve_pkg::NumW-1:0] num;

  always_comb begin
    ts_raw = t - pq_time;
    ts_fix = (ts_raw == 64'd0 || ts_raw > emve_pkg::TsMax) ? emve_pkg::TsDefault
                                                           : ts_raw[emve_pkg::TsW-1:0];
    sum = emve_pkg::DtW'(ts) + emve_pkg::DtW'(p_since);
    dt_calc = sum - th[emve_pkg::DtW-1:0];
    upd_calc = (d != 32'd0) && (th < 64'(sum)) &&
               ({1'b0, dt_calc, 1'b0} > 36'(ts));
    dmag = d[31] ? (32'd0 - d) : d;
    num = emve_pkg::NumW'(dmag) * emve_pkg::NumW'(emve_pkg::UsPerS);
  end

  // divider step
  logic [emve_pkg::DtW:0] rem_sh;
  logic        ge;
  logic [emve_pkg::DtW:0] rem_sub;
  always_comb begin
    rem_sh  = {rem, dvd[emve_pkg::DvdW-1]};
    ge      = rem_sh >= {1'b0, dt};
    rem_sub = rem_sh - {1'b0, dt};
  end

  // rate from quotient
  logic [47:0] rm;
  logic [47:0] new_rate;
  always_comb begin
    rm = (|dvd[emve_pkg::DvdW-1:47]) ? 48'h8000_0000_0000 : {1'b0, dvd[46:0]};
    if (d[31]) begin
      new_rate = 48'd0 - rm;
    end else begin
      new_rate = rm[47] ? 48'h7FFF_FFFF_FFFF : rm;
    end
  end

  // serial multiplier steps
  logic [35:0] sv_sum;
  logic [35:0] sa_sum;
  always_comb begin
    sv_sum = pv[emve_pkg::ProdW-1:emve_pkg::MulW] + (pv[0] ? {1'b0, apc} : 36'd0);
    sa_sum = pa[emve_pkg::ProdW-1:emve_pkg::MulW] + (pa[0] ? {1'b0, apc} : 36'd0);
  end

  // output saturation
  logic [51:0] vmag;
  logic [31:0] vel_out;
  logic [67:0] amag;
  logic [47:0] ang_out;
  always_comb begin
    vmag = pv[emve_pkg::ProdW-1:32];
    if (rate[47]) begin
      vel_out = (vmag > 52'h8000_0000) ? 32'h8000_0000 : 32'd0 - vmag[31:0];
    end else begin
      vel_out = (vmag > 52'h7FFF_FFFF) ? 32'h7FFF_FFFF : vmag[31:0];
    end
    amag = pa[emve_pkg::ProdW-1:16];
    if (held[31]) begin
      ang_out = (amag > 68'h8000_0000_0000) ? 48'h8000_0000_0000
                                            : 48'd0 - amag[47:0];
    end else begin
      ang_out = (amag > 68'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : amag[47:0];
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      apc        <= emve_pkg::ApcReset;
      timeout    <= emve_pkg::TimeoutReset;
      held       <= 32'd0;
      pulse_time <= 64'd0;
      pq_pos     <= 32'd0;
      pq_time    <= 64'd0;
      p_since    <= 32'd0;
      rate       <= 48'd0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          emve_pkg::REG_ANGLE:   apc <= cfg_data;
          emve_pkg::REG_TIMEOUT: timeout <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= operation;
            t  <= stamp_us;
            unique case (operation)
              emve_pkg::OP_SAMPLE: begin
                if (position_count != held) begin
                  pulse_time <= stamp_us;
                  held       <= position_count;
                end
                state <= S_MINIT;
              end
              emve_pkg::OP_QUERY: state <= S_QPREP;
              emve_pkg::OP_RESYNC: begin
                rate       <= 48'd0;
                p_since    <= 32'd0;
                pq_time    <= stamp_us;
                pulse_time <= stamp_us;
                pq_pos     <= position_count;
                held       <= position_count;
                state      <= S_MINIT;
              end
              default: state <= S_MINIT;
            endcase
          end
        end
        S_QPREP: begin
          ts    <= ts_fix;
          th    <= t - pulse_time;
          d     <= held - pq_pos;
          state <= S_QCALC;
        end
        S_QCALC: begin
          dt    <= dt_calc;
          upd   <= upd_calc;
          rem   <= '0;
          dvd   <= {num, 16'd0};
          cnt   <= 7'd0;
          state <= upd_calc ? S_DIV : S_QFIN;
        end
        S_DIV: begin
          rem <= ge ? rem_sub[emve_pkg::DtW-1:0] : rem_sh[emve_pkg::DtW-1:0];
          dvd <= {dvd[emve_pkg::DvdW-2:0], ge};
          cnt <= cnt + 7'd1;
          if (cnt == 7'(emve_pkg::DvdW - 1)) state <= S_QFIN;
        end
        S_QFIN: begin
          if (th > 64'(timeout)) rate <= 48'd0;
          else if (upd) rate <= new_rate;
          pq_time <= t;
          p_since <= (|th[63:32]) ? 32'hFFFF_FFFF : th[31:0];
          pq_pos  <= held;
          state   <= S_MINIT;
        end
        S_MINIT: begin
          pv    <= {36'd0, rate[47] ? 48'd0 - rate : rate};
          pa    <= {36'd0, 16'd0, held[31] ? 32'd0 - held : held};
          cnt   <= 7'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          pv  <= {1'b0, sv_sum, pv[emve_pkg::MulW-1:1]};
          pa  <= {1'b0, sa_sum, pa[emve_pkg::MulW-1:1]};
          cnt <= cnt + 7'd1;
          if (cnt == 7'(emve_pkg::MulW - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            held_count     <= held;
            angle_q16      <= ang_out;
            velocity_q16   <= vel_out;
            velocity_valid <= (op == emve_pkg::OP_QUERY);
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
